[rtl/sld_pkg.sv]
`default_nettype none
package sld_pkg;

    // Store geometry
    localparam int MAX_PAIRS  = 1024;
    localparam int VALUE_BITS = 20;
    localparam int ADDR_W     = $clog2(MAX_PAIRS);
    localparam int CNT_W      = ADDR_W + 1;

    // Result field widths
    localparam int DIST_W  = 31;
    localparam int SIM_W   = 41;
    localparam int PAIRS_W = 11;

    // Stream word widths, padded to whole bytes
    localparam int IN_DATA_W  = ((2 * VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((DIST_W + SIM_W + PAIRS_W + 7) / 8) * 8;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [ADDR_W-1:0]     t_addr;

    // Store write request: both lists share the address
    typedef struct packed {
        logic   we_l;
        logic   we_r;
        logic   bank;
        t_addr  addr;
        t_value data_l;
        t_value data_r;
    } t_wr;

    // Store read request: two read ports, one bank select
    typedef struct packed {
        logic  bank;
        t_addr addr_a;
        t_addr addr_b;
    } t_rdreq;

    // Store read data from the selected bank
    typedef struct packed {
        t_value l_a;
        t_value l_b;
        t_value r_a;
        t_value r_b;
    } t_rdata;

endpackage
`default_nettype wire

[rtl/sorted_list_distance_similarity_core.sv]
// Sorted-list distance and similarity core.
// Slave stream: one word per pair, tdata = {right_value, left_value} (20 bits
// each, left in the low bits), tlast marks the final pair of a set.
// While loading, the input is always ready. Up to 1024 pairs are stored;
// more are dropped and flagged.
// After the last pair the core stops taking words and sorts the left list,
// then the right list, with one shared merge unit over ping-pong store banks:
// each run starts with a setup step, then each element takes a read step and
// a merge-and-write step; ceil(log2 N) passes per list. Then the distance
// sum and the similarity sum follow, each as read and evaluate steps, one
// store read per evaluation.
// Master stream: one word per set, tdata = {pairs_used, similarity,
// total_distance} with total_distance from bit 0 up, tuser = overflowed.
// The result sits in an output register and the next set loads meanwhile;
// if the receiver still stalls when that set finishes, the core waits with
// its input not ready until the register frees up.
// Reset (synchronous, active low) empties the pair count, clears the drop
// flag and the output valid; store contents need no clearing.
`default_nettype none
module sorted_list_distance_similarity_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [19:0] left_value, [39:20] right_value
    input  wire logic [sld_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [30:0] total_distance, [71:31] similarity, [82:72] pairs_used
    output logic      [sld_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [0] overflowed
    output logic                                 m_axis_tuser
);
    import sld_pkg::*;

    t_wr    wr;
    t_rdreq rd;
    t_rdata rdata;
    t_value l0_a, l0_b, l1_a, l1_b, r0_a, r0_b, r1_a, r1_b;

    sld_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_wr          (wr),
        .o_rd          (rd),
        .i_rdata       (rdata)
    );

    // Left list, bank 0 and bank 1
    sld_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_PAIRS)) u_l0 (
        .i_clk(i_clk), .i_we(wr.we_l && !wr.bank), .i_waddr(wr.addr),
        .i_wdata(wr.data_l), .i_raddr_a(rd.addr_a), .i_raddr_b(rd.addr_b),
        .o_rdata_a(l0_a), .o_rdata_b(l0_b)
    );
    sld_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_PAIRS)) u_l1 (
        .i_clk(i_clk), .i_we(wr.we_l && wr.bank), .i_waddr(wr.addr),
        .i_wdata(wr.data_l), .i_raddr_a(rd.addr_a), .i_raddr_b(rd.addr_b),
        .o_rdata_a(l1_a), .o_rdata_b(l1_b)
    );

    // Right list, bank 0 and bank 1
    sld_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_PAIRS)) u_r0 (
        .i_clk(i_clk), .i_we(wr.we_r && !wr.bank), .i_waddr(wr.addr),
        .i_wdata(wr.data_r), .i_raddr_a(rd.addr_a), .i_raddr_b(rd.addr_b),
        .o_rdata_a(r0_a), .o_rdata_b(r0_b)
    );
    sld_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_PAIRS)) u_r1 (
        .i_clk(i_clk), .i_we(wr.we_r && wr.bank), .i_waddr(wr.addr),
        .i_wdata(wr.data_r), .i_raddr_a(rd.addr_a), .i_raddr_b(rd.addr_b),
        .o_rdata_a(r1_a), .o_rdata_b(r1_b)
    );

    // Source bank select
    assign rdata.l_a = rd.bank ? l1_a : l0_a;
    assign rdata.l_b = rd.bank ? l1_b : l0_b;
    assign rdata.r_a = rd.bank ? r1_a : r0_a;
    assign rdata.r_b = rd.bank ? r1_b : r0_b;
endmodule
`default_nettype wire

[rtl/sld_ram.sv]
`default_nettype none
module sld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

[rtl/sld_ctrl.sv]
`default_nettype none
module sld_ctrl (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [sld_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  wire logic                             s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic      [sld_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                                  m_axis_tuser,
    output sld_pkg::t_wr                          o_wr,
    output sld_pkg::t_rdreq                       o_rd,
    input  wire sld_pkg::t_rdata                  i_rdata
);
    import sld_pkg::*;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_MSET = 3'd1;
    localparam logic [2:0] S_MRD  = 3'd2;
    localparam logic [2:0] S_MEV  = 3'd3;
    localparam logic [2:0] S_DRD  = 3'd4;
    localparam logic [2:0] S_DEV  = 3'd5;
    localparam logic [2:0] S_SRD  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_drop, n_drop;
    logic [CNT_W-1:0]   r_n, n_n;
    logic               r_list, n_list;
    logic               r_src, n_src;
    logic [CNT_W-1:0]   r_w, n_w;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_mid, n_mid;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic [CNT_W-1:0]   r_i, n_i;
    logic [CNT_W-1:0]   r_j, n_j;
    logic [CNT_W-1:0]   r_k, n_k;
    logic               r_phase, n_phase;
    logic               r_sevl, n_sevl;
    logic [DIST_W-1:0]  r_dist, n_dist;
    logic [SIM_W-1:0]   r_sim, n_sim;
    logic               r_ovalid, n_ovalid;
    logic [OUT_DATA_W-1:0] r_odata, n_odata;
    logic               r_oflow, n_oflow;

    logic [CNT_W-1:0]   cnt_after;
    logic [CNT_W:0]     sum_mid, sum_hi, lo_nx, w2;
    t_value             a_val, b_val, diff;
    logic               take_b;

    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_oflow;

    // Read addresses follow the pointers directly; the wait step of the
    // match scan fetches the right entry at r_k
    assign o_rd.bank   = r_src;
    assign o_rd.addr_a = r_i[ADDR_W-1:0];
    assign o_rd.addr_b = (r_state == S_SRD && !r_sevl && r_phase) ? r_k[ADDR_W-1:0]
                                                                  : r_j[ADDR_W-1:0];

    // Merge operands of the list under sort
    assign a_val   = r_list ? i_rdata.r_a : i_rdata.l_a;
    assign b_val   = r_list ? i_rdata.r_b : i_rdata.l_b;
    assign take_b  = (r_i >= r_mid) || ((r_j < r_hi) && (b_val < a_val));
    assign sum_mid = {1'b0, r_lo} + {1'b0, r_w};
    assign sum_hi  = {1'b0, r_lo} + {r_w, 1'b0};
    assign lo_nx   = sum_hi;
    assign w2      = {r_w, 1'b0};
    assign diff    = (i_rdata.l_a > i_rdata.r_a) ? i_rdata.l_a - i_rdata.r_a
                                                 : i_rdata.r_a - i_rdata.l_a;
    assign cnt_after = (r_cnt < CNT_W'(MAX_PAIRS)) ? r_cnt + 1'b1 : r_cnt;

    // Sequencer
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_drop = r_drop; n_n = r_n;
        n_list = r_list; n_src = r_src; n_w = r_w; n_lo = r_lo;
        n_mid = r_mid; n_hi = r_hi; n_i = r_i; n_j = r_j; n_k = r_k;
        n_phase = r_phase; n_sevl = r_sevl; n_dist = r_dist; n_sim = r_sim;
        n_ovalid = r_ovalid; n_odata = r_odata; n_oflow = r_oflow;
        o_wr = '0;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_LOAD: begin
                if (s_axis_tvalid) begin
                    if (r_cnt < CNT_W'(MAX_PAIRS)) begin
                        o_wr.we_l   = 1'b1;
                        o_wr.we_r   = 1'b1;
                        o_wr.addr   = r_cnt[ADDR_W-1:0];
                        o_wr.data_l = s_axis_tdata[VALUE_BITS-1:0];
                        o_wr.data_r = s_axis_tdata[2*VALUE_BITS-1:VALUE_BITS];
                    end else begin
                        n_drop = 1'b1;
                    end
                    n_cnt = cnt_after;
                    if (s_axis_tlast) begin
                        n_n    = cnt_after;
                        n_list = 1'b0;
                        n_src  = 1'b0;
                        n_w    = CNT_W'(1);
                        n_lo   = '0;
                        n_i    = '0;
                        n_dist = '0;
                        n_sim  = '0;
                        n_state = (cnt_after <= CNT_W'(1)) ? S_DRD : S_MSET;
                    end
                end
            end
            S_MSET: begin
                n_mid = (sum_mid >= {1'b0, r_n}) ? r_n : sum_mid[CNT_W-1:0];
                n_hi  = (sum_hi  >= {1'b0, r_n}) ? r_n : sum_hi[CNT_W-1:0];
                n_i   = r_lo;
                n_j   = (sum_mid >= {1'b0, r_n}) ? r_n : sum_mid[CNT_W-1:0];
                n_k   = r_lo;
                n_state = S_MRD;
            end
            S_MRD: begin
                n_state = S_MEV;
            end
            S_MEV: begin
                o_wr.we_l   = !r_list;
                o_wr.we_r   = r_list;
                o_wr.bank   = !r_src;
                o_wr.addr   = r_k[ADDR_W-1:0];
                o_wr.data_l = take_b ? b_val : a_val;
                o_wr.data_r = take_b ? b_val : a_val;
                if (take_b) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
                n_k = r_k + 1'b1;
                n_state = S_MRD;
                if (r_k + 1'b1 == r_hi) begin
                    n_state = S_MSET;
                    if (lo_nx >= {1'b0, r_n}) begin
                        // pass done: swap banks, double the run width or end the list's sort
                        n_src = !r_src;
                        n_lo  = '0;
                        if (w2 >= {1'b0, r_n}) begin
                            if (!r_list) begin
                                n_list = 1'b1;
                                n_src  = 1'b0;
                                n_w    = CNT_W'(1);
                            end else begin
                                n_i     = '0;
                                n_state = S_DRD;
                            end
                        end else begin
                            n_w = w2[CNT_W-1:0];
                        end
                    end else begin
                        n_lo = lo_nx[CNT_W-1:0];
                    end
                end
            end
            S_DRD: begin
                n_state = S_DEV;
            end
            S_DEV: begin
                n_dist = r_dist + DIST_W'(diff);
                if (r_i + 1'b1 == r_n) begin
                    n_i = '0; n_j = '0; n_k = '0;
                    n_phase = 1'b0;
                    n_sevl  = 1'b0;
                    n_state = S_SRD;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_DRD;
                end
            end
            S_SRD: begin
                // r_sevl low: wait for read data, high: evaluate
                n_sevl = !r_sevl;
                if (r_sevl) begin
                    if (!r_phase) begin
                        if (r_j < r_n && i_rdata.r_b < i_rdata.l_a) begin
                            n_j = r_j + 1'b1;
                        end else begin
                            n_k = r_j;
                            n_phase = 1'b1;
                        end
                    end else if (r_k < r_n && i_rdata.r_b == i_rdata.l_a) begin
                        n_sim = r_sim + SIM_W'(i_rdata.l_a);
                        n_k   = r_k + 1'b1;
                    end else begin
                        n_phase = 1'b0;
                        if (r_i + 1'b1 == r_n) begin
                            n_state = S_OUT;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = OUT_DATA_W'({PAIRS_W'(r_n), r_sim, r_dist});
                    n_oflow  = r_drop;
                    n_cnt    = '0;
                    n_drop   = 1'b0;
                    n_state  = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
            r_sevl   <= 1'b0;
            r_phase  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_drop   <= n_drop;
            r_ovalid <= n_ovalid;
            r_sevl   <= n_sevl;
            r_phase  <= n_phase;
        end
    end

    // Pointers and sums
    always_ff @(posedge i_clk) begin
        r_n <= n_n; r_list <= n_list; r_src <= n_src; r_w <= n_w;
        r_lo <= n_lo; r_mid <= n_mid; r_hi <= n_hi;
        r_i <= n_i; r_j <= n_j; r_k <= n_k;
        r_dist <= n_dist; r_sim <= n_sim;
        r_odata <= n_odata; r_oflow <= n_oflow;
    end
endmodule
`default_nettype wire

[rtl/sld_checker.sv]
`default_nettype none
module sld_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            s_axis_tlast,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [sld_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input wire logic                            m_axis_tuser
);
    // Stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // Core goes busy after the last pair of a set
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("core took a word right after a last pair");

    // Pair count within capacity and never zero
    a_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[82:72] != 11'd0
            && m_axis_tdata[82:72] <= 11'd1024)
        else $error("pairs_used out of range");

    // Drop flag only with a full store
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[82:72] == 11'd1024)
        else $error("overflow flagged with a store not full");

    // No result word straight out of reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
endmodule

bind sorted_list_distance_similarity_core sld_checker u_sld_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

[tb/tb_sorted_list_distance_similarity_core.sv]
`default_nettype none
module tb_sorted_list_distance_similarity_core;
    timeunit 1ns;
    timeprecision 1ps;
    import sld_pkg::*;

    localparam int  CYCLE_LIMIT = 3_000_000;
    localparam int  HOLD_CYCLES = 2000;
    localparam int  ITEM_GOAL   = 1550;
    localparam int  BIG_SET     = MAX_PAIRS + 6;
    localparam bit [VALUE_BITS-1:0] VMAX = '1;

    // One set's result as the core reports it
    typedef struct packed {
        logic [DIST_W-1:0]  tdist;
        logic [SIM_W-1:0]   sim;
        logic [PAIRS_W-1:0] pairs;
        logic               ovf;
    } t_sums;

    // Directed row: one pair, optionally with its result typed in
    typedef struct packed {
        t_value l;
        t_value r;
        logic   last;
        logic   typed;
        t_sums  want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    sorted_list_distance_similarity_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: the lists of the set being loaded
    t_value left_list[$];
    t_value right_list[$];
    logic   dropped = 1'b0;
    t_sums  sums_due[$];

    int  errors = 0;
    int  sets_checked = 0;
    int  pairs_sent = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    t_row rows[$];

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sorted_list_distance_similarity_core: mismatch");
            $finish;
        end
    end

    function automatic bit idle_now();
        return !quiet && ($urandom_range(0, 99) < 15);
    endfunction

    task automatic sort_vals(ref t_value a[$]);
        t_value v;
        int j;
        for (int i = 1; i < a.size(); i++) begin
            v = a[i];
            j = i - 1;
            while (j >= 0 && a[j] > v) begin
                a[j+1] = a[j];
                j--;
            end
            a[j+1] = v;
        end
    endtask

    // Load one pair into the predicted store; on the last pair compute both sums
    task automatic predict_pair(input t_value l, input t_value r, input logic last,
                                input logic typed, input t_sums want);
        t_sums s;
        logic [63:0] dist_acc;
        logic [63:0] sim;
        int n, j, k;
        dist_acc = 0;
        sim = 0;
        if (left_list.size() < MAX_PAIRS) begin
            left_list.push_back(l);
            right_list.push_back(r);
        end else begin
            dropped = 1'b1;
        end
        if (last) begin
            sort_vals(left_list);
            sort_vals(right_list);
            n = left_list.size();
            j = 0;
            for (int i = 0; i < n; i++) begin
                dist_acc += (left_list[i] > right_list[i]) ? left_list[i] - right_list[i]
                                                           : right_list[i] - left_list[i];
                while (j < n && right_list[j] < left_list[i]) j++;
                k = j;
                while (k < n && right_list[k] == left_list[i]) k++;
                sim += 64'(left_list[i]) * 64'(k - j);
            end
            s.tdist = dist_acc[DIST_W-1:0];
            s.sim = sim[SIM_W-1:0];
            s.pairs = PAIRS_W'(n);
            s.ovf = dropped;
            sums_due.push_back(typed ? want : s);
            left_list.delete();
            right_list.delete();
            dropped = 1'b0;
        end
    endtask

    // Offer one word, with random gaps ahead of it; returns after acceptance
    task automatic send_pair(input t_value l, input t_value r, input logic last,
                             input logic typed = 1'b0, input t_sums want = '0);
        bit taken;
        while (idle_now()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_DATA_W'({r, l});
        s_axis_tlast <= last;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        predict_pair(l, r, last, typed, want);
        pairs_sent++;
    endtask

    function automatic t_value pick(input int mode);
        case (mode)
            0: return t_value'($urandom);
            1: return t_value'($urandom_range(0, 7));
            default: return $urandom_range(0, 1) ? VMAX : '0;
        endcase
    endfunction

    task automatic send_set(input int n, input int mode);
        for (int i = 0; i < n; i++) send_pair(pick(mode), pick(mode), i == n - 1);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sums_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_row mk(input t_value l, input t_value r, input logic last,
                                input logic typed, input logic [DIST_W-1:0] d = '0,
                                input logic [SIM_W-1:0] s = '0);
        t_row x;
        x.l = l;
        x.r = r;
        x.last = last;
        x.typed = typed;
        x.want.tdist = d;
        x.want.sim = s;
        x.want.pairs = 1;
        x.want.ovf = 1'b0;
        return x;
    endfunction

    // Receiver: random stalls, one long hold-off on request, word check
    initial begin
        bit got;
        t_sums act, exp_s;
        forever begin
            @(negedge i_clk);
            got = m_axis_tvalid && m_axis_tready;
            act.tdist = m_axis_tdata[30:0];
            act.sim = m_axis_tdata[71:31];
            act.pairs = m_axis_tdata[82:72];
            act.ovf = m_axis_tuser;
            @(posedge i_clk);
            if (got) begin
                if (sums_due.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, act);
                    errors++;
                end else begin
                    exp_s = sums_due.pop_front();
                    sets_checked++;
                    if (act.tdist !== exp_s.tdist)
                        $display("%0t: total_distance exp %0d got %0d", $time,
                                 exp_s.tdist, act.tdist);
                    if (act.sim !== exp_s.sim)
                        $display("%0t: similarity exp %0d got %0d", $time,
                                 exp_s.sim, act.sim);
                    if (act.pairs !== exp_s.pairs)
                        $display("%0t: pairs_used exp %0d got %0d", $time,
                                 exp_s.pairs, act.pairs);
                    if (act.ovf !== exp_s.ovf)
                        $display("%0t: overflowed exp %0b got %0b", $time,
                                 exp_s.ovf, act.ovf);
                    if (act !== exp_s) errors++;
                end
            end
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !idle_now();
            end
        end
    end

    // Sender
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single pairs at the extremes, small sets with duplicates
        rows.push_back(mk('0, '0, 1, 1, 0, 0));
        rows.push_back(mk(VMAX, '0, 1, 1, DIST_W'(VMAX), 0));
        rows.push_back(mk('0, VMAX, 1, 1, DIST_W'(VMAX), 0));
        rows.push_back(mk(VMAX, VMAX, 1, 1, 0, SIM_W'(VMAX)));
        rows.push_back(mk(5, 3, 0, 0));
        rows.push_back(mk(3, 5, 0, 0));
        rows.push_back(mk(7, 7, 1, 0));
        rows.push_back(mk(2, 2, 0, 0));
        rows.push_back(mk(2, 2, 0, 0));
        rows.push_back(mk(2, 9, 1, 0));
        rows.push_back(mk(20'hAAAAA, 20'h55555, 0, 0));
        rows.push_back(mk(20'h55555, 20'hAAAAA, 0, 0));
        rows.push_back(mk('0, VMAX, 0, 0));
        rows.push_back(mk(VMAX, '0, 1, 0));
        rows.push_back(mk(1, 0, 0, 0));
        rows.push_back(mk(0, 1, 1, 0));
        foreach (rows[i])
            send_pair(rows[i].l, rows[i].r, rows[i].last, rows[i].typed, rows[i].want);
        drain();

        // Full store plus dropped pairs, the last one dropped too
        quiet = 1'b1;
        send_set(BIG_SET, 0);
        drain();
        quiet = 1'b0;

        // Long receiver hold-off while small sets keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) send_set($urandom_range(1, 4), $urandom_range(0, 2));
        drain();

        while (pairs_sent < ITEM_GOAL) begin
            quiet = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) == 0) send_set($urandom_range(20, 40), $urandom_range(0, 2));
            else send_set($urandom_range(1, 8), $urandom_range(0, 2));
        end
        quiet = 1'b0;
        drain();
        repeat (100) @(posedge i_clk);

        $display("%0d pairs sent, %0d sets checked: extremes, duplicates, store overflow,",
                 pairs_sent, sets_checked);
        $display("random small sets, random stalls and a long receiver hold-off");
        if (errors == 0) begin
            $display("sorted_list_distance_similarity_core: match");
        end else begin
            $display("sorted_list_distance_similarity_core: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
